// File: src/sbfd_pkg.sv
// Shared types, constants and helpers for the sensor burst frame deframer.
package sbfd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BURST_SEL    = 2'd0,
    REG_INCLINE_CTRL = 2'd1,
    REG_HEADER_BYTE  = 2'd2,
    REG_DELIM_BYTE   = 2'd3
  } cfg_reg_t;

  localparam int CFG_DATA_W = 16;

  // burst select enable bits
  localparam int BC_FLAGS = 15;
  localparam int BC_TEMP  = 14;
  localparam int BC_X     = 10;
  localparam int BC_Y     = 9;
  localparam int BC_Z     = 8;
  localparam int BC_COUNT = 1;
  localparam int BC_CSUM  = 0;

  // incline_ctrl tilt-select bits
  localparam int IC_X = 7;
  localparam int IC_Y = 6;
  localparam int IC_Z = 5;

  // present_mask bit positions
  localparam int PM_FLAGS = 0;
  localparam int PM_TEMP  = 1;
  localparam int PM_X     = 2;
  localparam int PM_Y     = 3;
  localparam int PM_Z     = 4;
  localparam int PM_COUNT = 5;
  localparam int PM_CSUM  = 6;
  localparam int PM_W     = 7;

  // status bits
  localparam int ST_HDR_BAD   = 0;
  localparam int ST_DELIM_BAD = 1;

  localparam logic [7:0]  HEADER_RST = 8'h80;
  localparam logic [7:0]  DELIM_RST  = 8'h0D;

  typedef logic [PM_W-1:0] pmask_t;

  // Map burst select enables onto present_mask order
  function automatic pmask_t present_bits(input logic [15:0] bc);
    pmask_t m;
    m[PM_FLAGS] = bc[BC_FLAGS];
    m[PM_TEMP]  = bc[BC_TEMP];
    m[PM_X]     = bc[BC_X];
    m[PM_Y]     = bc[BC_Y];
    m[PM_Z]     = bc[BC_Z];
    m[PM_COUNT] = bc[BC_COUNT];
    m[PM_CSUM]  = bc[BC_CSUM];
    return m;
  endfunction

endpackage

// File: src/sensor_burst_frame_deframer.sv
// Top level: deframes accelerometer burst replies into one result item per frame.
//
// Usage:
//  - in_* channel takes one received UART byte per item (valid/ready).
//  - out_* channel gives one item per frame, on the delimiter byte, carrying
//    status, presence and tilt masks and every raw field (absent fields zero).
//  - cfg_* is a plain write port: cfg_we with cfg_index selects burst select,
//    incline_ctrl, header_byte or delimiter_byte; write only while idle.
//  - Frame length is the header byte, the enabled payload bytes (up to 22)
//    and the delimiter byte.
// Timing:
//  - One byte per cycle is taken while in_ready is high; each byte updates the
//    position counter and the holding registers in the cycle it is accepted.
//  - The result item is loaded into the output register when the delimiter
//    byte is accepted.
//  - in_ready drops only while a finished result waits and out_ready is low;
//    the output register is the only thing that holds the input side back.
// Reset (synchronous, rst_n low): position returns to awaiting header, the
//  output register empties, configuration returns to its reset values.
module sensor_burst_frame_deframer
  import sbfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [6:0]            out_present_mask,
  output logic [2:0]            out_tilt_mask,
  output logic [15:0]           out_nd_flags,
  output logic signed [31:0]    out_temperature_raw,
  output logic signed [31:0]    out_axis_x_raw,
  output logic signed [31:0]    out_axis_y_raw,
  output logic signed [31:0]    out_axis_z_raw,
  output logic [15:0]           out_sample_count,
  output logic [15:0]           out_checksum_word
);

  // configuration
  logic [15:0] burst_sel_r;
  logic [7:0]  incline_ctrl_r;
  logic [7:0]  header_byte_r;
  logic [7:0]  delim_byte_r;

  // frame state
  logic [4:0]  pos_r, pos_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] nd_r, nd_nxt;
  logic [31:0] temp_r, temp_nxt;
  logic [31:0] ax_r, ax_nxt;
  logic [31:0] ay_r, ay_nxt;
  logic [31:0] az_r, az_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] csum_r, csum_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  status_r;
  pmask_t      pmask_r;
  logic [2:0]  tilt_r;
  logic [15:0] o_nd_r, o_cnt_r, o_csum_r;
  logic [31:0] o_temp_r, o_ax_r, o_ay_r, o_az_r;

  pmask_t      pm;
  logic [3:0]  off_temp, off_x, off_y, off_z, off_cnt, off_csum, n_words;
  logic [4:0]  last_pos;
  logic [4:0]  rel;
  logic [3:0]  k;
  logic [15:0] word;
  logic        in_fire;
  logic        emit;
  logic [2:0]  tilt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Word offsets of each field inside the payload
  always_comb begin
    pm       = present_bits(burst_sel_r);
    off_temp = {3'b0, pm[PM_FLAGS]};
    off_x    = off_temp + {2'b0, pm[PM_TEMP], 1'b0};
    off_y    = off_x + {2'b0, pm[PM_X], 1'b0};
    off_z    = off_y + {2'b0, pm[PM_Y], 1'b0};
    off_cnt  = off_z + {2'b0, pm[PM_Z], 1'b0};
    off_csum = off_cnt + {3'b0, pm[PM_COUNT]};
    n_words  = off_csum + {3'b0, pm[PM_CSUM]};
    // header sits at position 0, payload bytes at 1..2*n_words
    last_pos = {n_words, 1'b0} + 5'd1;
    tilt     = {pm[PM_Z] & incline_ctrl_r[IC_Z],
                pm[PM_Y] & incline_ctrl_r[IC_Y],
                pm[PM_X] & incline_ctrl_r[IC_X]};
  end

  assign rel  = pos_r - 5'd1;
  assign k    = rel[4:1];
  assign word = {hi_r, in_rx_byte};

  // Byte handling: header, payload, delimiter
  always_comb begin
    pos_nxt    = pos_r;
    hdr_ok_nxt = hdr_ok_r;
    hi_nxt     = hi_r;
    nd_nxt     = nd_r;
    temp_nxt   = temp_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    az_nxt     = az_r;
    cnt_nxt    = cnt_r;
    csum_nxt   = csum_r;
    emit       = 1'b0;
    if (in_fire) begin
      if (pos_r == 5'd0) begin
        // header: clear holds so absent fields read zero
        hdr_ok_nxt = (in_rx_byte == header_byte_r);
        hi_nxt     = '0;
        nd_nxt     = '0;
        temp_nxt   = '0;
        ax_nxt     = '0;
        ay_nxt     = '0;
        az_nxt     = '0;
        cnt_nxt    = '0;
        csum_nxt   = '0;
        pos_nxt    = 5'd1;
      end else if (pos_r < last_pos) begin
        if (!rel[0]) begin
          hi_nxt = in_rx_byte;
        end else begin
          if (pm[PM_FLAGS] && k == 4'd0) nd_nxt = word;
          if (pm[PM_TEMP] && k == off_temp)        temp_nxt[31:16] = word;
          if (pm[PM_TEMP] && k == off_temp + 4'd1) temp_nxt[15:0]  = word;
          if (pm[PM_X] && k == off_x)              ax_nxt[31:16]   = word;
          if (pm[PM_X] && k == off_x + 4'd1)       ax_nxt[15:0]    = word;
          if (pm[PM_Y] && k == off_y)              ay_nxt[31:16]   = word;
          if (pm[PM_Y] && k == off_y + 4'd1)       ay_nxt[15:0]    = word;
          if (pm[PM_Z] && k == off_z)              az_nxt[31:16]   = word;
          if (pm[PM_Z] && k == off_z + 4'd1)       az_nxt[15:0]    = word;
          if (pm[PM_COUNT] && k == off_cnt)        cnt_nxt         = word;
          if (pm[PM_CSUM] && k == off_csum)        csum_nxt        = word;
        end
        pos_nxt = pos_r + 5'd1;
      end else begin
        // delimiter position reached (or passed): close the frame
        emit       = 1'b1;
        pos_nxt    = 5'd0;
        hdr_ok_nxt = 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_sel_r    <= '0;
      incline_ctrl_r <= '0;
      header_byte_r  <= HEADER_RST;
      delim_byte_r   <= DELIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BURST_SEL:    burst_sel_r    <= cfg_wdata;
        REG_INCLINE_CTRL: incline_ctrl_r <= cfg_wdata[7:0];
        REG_HEADER_BYTE:  header_byte_r  <= cfg_wdata[7:0];
        REG_DELIM_BYTE:   delim_byte_r   <= cfg_wdata[7:0];
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_ok_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  // Holding registers need no reset: the header clears them
  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    nd_r   <= nd_nxt;
    temp_r <= temp_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    az_r   <= az_nxt;
    cnt_r  <= cnt_nxt;
    csum_r <= csum_nxt;
  end

  // Output register: load on frame end, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r[ST_HDR_BAD]   <= !hdr_ok_r;
      status_r[ST_DELIM_BAD] <= (in_rx_byte != delim_byte_r);
      pmask_r  <= pm;
      tilt_r   <= tilt;
      o_nd_r   <= pm[PM_FLAGS] ? nd_r   : '0;
      o_temp_r <= pm[PM_TEMP]  ? temp_r : '0;
      o_ax_r   <= pm[PM_X]     ? ax_r   : '0;
      o_ay_r   <= pm[PM_Y]     ? ay_r   : '0;
      o_az_r   <= pm[PM_Z]     ? az_r   : '0;
      o_cnt_r  <= pm[PM_COUNT] ? cnt_r  : '0;
      o_csum_r <= pm[PM_CSUM]  ? csum_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_present_mask    = pmask_r;
  assign out_tilt_mask       = tilt_r;
  assign out_nd_flags        = o_nd_r;
  assign out_temperature_raw = o_temp_r;
  assign out_axis_x_raw      = o_ax_r;
  assign out_axis_y_raw      = o_ay_r;
  assign out_axis_z_raw      = o_az_r;
  assign out_sample_count    = o_cnt_r;
  assign out_checksum_word   = o_csum_r;

endmodule

// File: src/sbfd_checker.sv
// Port-level checker for the sensor burst frame deframer, bound to the top level.
module sbfd_checker
  import sbfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_status,
  input logic [6:0]            out_present_mask,
  input logic [2:0]            out_tilt_mask,
  input logic [15:0]           out_nd_flags,
  input logic signed [31:0]    out_temperature_raw,
  input logic signed [31:0]    out_axis_x_raw,
  input logic signed [31:0]    out_axis_y_raw,
  input logic signed [31:0]    out_axis_z_raw,
  input logic [15:0]           out_sample_count,
  input logic [15:0]           out_checksum_word
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // Input side never stalls while no result waits
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_present_mask) && $stable(out_axis_x_raw)
      && $stable(out_nd_flags))
    else $error("stalled result item changed");

  // Tilt only on present axes
  a_tilt_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tilt_mask & ~out_present_mask[PM_Z:PM_X]) == 3'b000)
    else $error("tilt flagged on absent axis");

  // Absent fields read zero
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_present_mask[PM_FLAGS] || out_nd_flags == '0)
      && (out_present_mask[PM_TEMP] || out_temperature_raw == '0)
      && (out_present_mask[PM_X] || out_axis_x_raw == '0)
      && (out_present_mask[PM_Y] || out_axis_y_raw == '0)
      && (out_present_mask[PM_Z] || out_axis_z_raw == '0)
      && (out_present_mask[PM_COUNT] || out_sample_count == '0)
      && (out_present_mask[PM_CSUM] || out_checksum_word == '0))
    else $error("absent field not zero");

endmodule

bind sensor_burst_frame_deframer sbfd_checker u_sbfd_checker (.*);

// File: tb/sensor_burst_frame_deframer_test.sv
// Self-checking testbench for the sensor burst frame deframer.
module sensor_burst_frame_deframer_test;
  import sbfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4;
  localparam int SEG_BYTES    = 20;

  // One frame result as the block reports it
  typedef struct packed {
    logic [1:0]  stat;
    logic [6:0]  present;
    logic [2:0]  tilt;
    logic [15:0] flags;
    logic [31:0] temperature;
    logic [31:0] axis_x;
    logic [31:0] axis_y;
    logic [31:0] axis_z;
    logic [15:0] count;
    logic [15:0] csum;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_BURST_SEL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [6:0]            out_present_mask;
  logic [2:0]            out_tilt_mask;
  logic [15:0]           out_nd_flags;
  logic signed [31:0]    out_temperature_raw;
  logic signed [31:0]    out_axis_x_raw;
  logic signed [31:0]    out_axis_y_raw;
  logic signed [31:0]    out_axis_z_raw;
  logic [15:0]           out_sample_count;
  logic [15:0]           out_checksum_word;

  sensor_burst_frame_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_present_mask    (out_present_mask),
    .out_tilt_mask       (out_tilt_mask),
    .out_nd_flags        (out_nd_flags),
    .out_temperature_raw (out_temperature_raw),
    .out_axis_x_raw      (out_axis_x_raw),
    .out_axis_y_raw      (out_axis_y_raw),
    .out_axis_z_raw      (out_axis_z_raw),
    .out_sample_count    (out_sample_count),
    .out_checksum_word   (out_checksum_word)
  );

  always #2 clk = ~clk;

  // Byte stream waiting to go out, and frame results still owed by the block
  logic [7:0]    rx_stream [$];
  frame_result_t expected_frames [$];

  // Idling knobs, in percent, changed per phase
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;

  // Bookkeeping
  int  cycle_count    = 0;
  int  fault_count    = 0;
  int  frames_checked = 0;
  int  random_bytes   = 0;
  int  reg_writes     = 0;
  bit  byte_taken     = 1'b0;

  // Predictor copy of the configuration registers
  logic [15:0] burst_sel_q;
  logic [7:0]  incline_ctrl_q;
  logic [7:0]  header_q;
  logic [7:0]  delim_q;

  // Predictor copy of the deframing state
  logic [4:0]  pos;
  logic        hdr_ok;
  logic [7:0]  hi_hold;
  logic [15:0] word_hold;
  logic [15:0] nd_hold;
  logic [31:0] temp_hold;
  logic [31:0] axis_hold [3];
  logic [15:0] count_hold;
  logic [15:0] csum_hold;

  initial begin
    burst_sel_q    = 16'h0000;
    incline_ctrl_q = 8'h00;
    header_q       = HEADER_RST;
    delim_q        = DELIM_RST;
    pos            = '0;
    hdr_ok         = 1'b0;
  end

  // Reorder burst select enables into present-mask bit order
  function automatic pmask_t enabled_fields(input logic [15:0] bc);
    return {bc[BC_CSUM], bc[BC_COUNT], bc[BC_Z], bc[BC_Y], bc[BC_X], bc[BC_TEMP],
            bc[BC_FLAGS]};
  endfunction

  // Flags, count and checksum take one word; temperature and axes take two
  function automatic int field_words(input int slot);
    return (slot == PM_FLAGS || slot == PM_COUNT || slot == PM_CSUM) ? 1 : 2;
  endfunction

  function automatic int payload_bytes(input pmask_t pm);
    int total;
    total = 0;
    for (int slot = 0; slot < PM_W; slot++)
      if (pm[slot]) total += 2 * field_words(slot);
    return total;
  endfunction

  // Route one assembled payload word to the field it lands in
  function automatic void place_word(input pmask_t pm, input int word_idx,
                                     input logic [15:0] w);
    int k;
    int span;
    k = word_idx;
    for (int slot = 0; slot < PM_W; slot++) begin
      if (pm[slot]) begin
        span = field_words(slot);
        if (k < span) begin
          case (slot)
            PM_FLAGS: nd_hold = w;
            PM_TEMP: begin
              if (k == 0) temp_hold[31:16] = w;
              else temp_hold[15:0] = w;
            end
            PM_COUNT: count_hold = w;
            PM_CSUM:  csum_hold = w;
            default: begin
              if (k == 0) axis_hold[slot-PM_X][31:16] = w;
              else axis_hold[slot-PM_X][15:0] = w;
            end
          endcase
          return;
        end
        k -= span;
      end
    end
  endfunction

  // Advance the predicted deframer by one accepted byte; queue a result at the
  // frame end. Layout and length follow the live configuration at every byte.
  function automatic void deframe_byte(input logic [7:0] b);
    pmask_t        pm;
    int            last_pos;
    int            rel;
    frame_result_t r;
    pm       = enabled_fields(burst_sel_q);
    last_pos = payload_bytes(pm) + 1;
    if (pos == 0) begin
      // Header slot: clear every hold so absent fields read zero
      hi_hold    = '0;
      word_hold  = '0;
      nd_hold    = '0;
      temp_hold  = '0;
      axis_hold[0] = '0;
      axis_hold[1] = '0;
      axis_hold[2] = '0;
      count_hold = '0;
      csum_hold  = '0;
      hdr_ok     = (b == header_q);
      pos        = 5'd1;
    end else if (int'(pos) < last_pos) begin
      rel = int'(pos) - 1;
      if (rel % 2 == 0) begin
        hi_hold = b;
      end else begin
        word_hold = {hi_hold, b};
        place_word(pm, rel / 2, word_hold);
      end
      pos = pos + 5'd1;
    end else begin
      // Delimiter slot, or past it after a shrinking burst select write
      r.stat[ST_HDR_BAD]   = !hdr_ok;
      r.stat[ST_DELIM_BAD] = (b != delim_q);
      r.present     = pm;
      r.tilt        = {pm[PM_Z] & incline_ctrl_q[IC_Z], pm[PM_Y] & incline_ctrl_q[IC_Y],
                       pm[PM_X] & incline_ctrl_q[IC_X]};
      r.flags       = pm[PM_FLAGS] ? nd_hold : 16'h0000;
      r.temperature = pm[PM_TEMP] ? temp_hold : 32'h0;
      r.axis_x      = pm[PM_X] ? axis_hold[0] : 32'h0;
      r.axis_y      = pm[PM_Y] ? axis_hold[1] : 32'h0;
      r.axis_z      = pm[PM_Z] ? axis_hold[2] : 32'h0;
      r.count       = pm[PM_COUNT] ? count_hold : 16'h0000;
      r.csum        = pm[PM_CSUM] ? csum_hold : 16'h0000;
      expected_frames.push_back(r);
      pos    = '0;
      hdr_ok = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("frame %0d: %s expected %h, got %h", frames_checked, name, want, got);
    end
  endfunction

  // Run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still owed", cycle_count,
               expected_frames.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Monitor: predict on every accepted byte, check every accepted result item
  always @(posedge clk) begin : watch_outputs
    frame_result_t want;
    byte_taken = rst_n && in_valid && in_ready;
    if (byte_taken) deframe_byte(in_rx_byte);
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result item: status %0d present %h", out_status,
                   out_present_mask);
      end else begin
        want = expected_frames.pop_front();
        check_field("status",          32'(want.stat),    32'(out_status));
        check_field("present_mask",    32'(want.present), 32'(out_present_mask));
        check_field("tilt_mask",       32'(want.tilt),    32'(out_tilt_mask));
        check_field("nd_flags",        32'(want.flags),   32'(out_nd_flags));
        check_field("temperature_raw", want.temperature,  out_temperature_raw);
        check_field("axis_x_raw",      want.axis_x,       out_axis_x_raw);
        check_field("axis_y_raw",      want.axis_y,       out_axis_y_raw);
        check_field("axis_z_raw",      want.axis_z,       out_axis_z_raw);
        check_field("sample_count",    32'(want.count),   32'(out_sample_count));
        check_field("checksum_word",   32'(want.csum),    32'(out_checksum_word));
        frames_checked++;
      end
    end
  end

  // Driver: hold valid and the byte until taken, then pop the next one or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (rx_stream.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random per the current phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Wait until every queued byte is taken and every owed result has arrived,
  // then let the block settle on any byte that produces no result.
  task automatic wait_idle();
    do @(posedge clk);
    while (rx_stream.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Write one register and mirror it into the predictor (block is idle here)
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BURST_SEL:    burst_sel_q    = val;
      REG_INCLINE_CTRL: incline_ctrl_q = val[7:0];
      REG_HEADER_BYTE:  header_q       = val[7:0];
      REG_DELIM_BYTE:   delim_q        = val[7:0];
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Draw a fresh setting for all four registers, leaning on the extremes
  task automatic pick_settings();
    logic [15:0] bc;
    logic [7:0]  ic;
    logic [7:0]  hb;
    logic [7:0]  db;
    case ($urandom_range(0, 3))
      0:       bc = 16'hFFFF;
      1:       bc = 16'h0000;
      default: bc = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 2))
      0:       ic = 8'hFF;
      1:       ic = 8'h00;
      default: ic = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       hb = HEADER_RST;
      1:       hb = 8'h00;
      2:       hb = 8'hFF;
      default: hb = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       db = DELIM_RST;
      1:       db = 8'h00;
      2:       db = 8'hFF;
      default: db = 8'($urandom_range(0, 255));
    endcase
    write_reg(REG_BURST_SEL, bc);
    write_reg(REG_INCLINE_CTRL, {8'h00, ic});
    write_reg(REG_HEADER_BYTE, {8'h00, hb});
    write_reg(REG_DELIM_BYTE, {8'h00, db});
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue mostly well-formed frames for the current setting, with some bad
  // headers, bad delimiters and loose noise bytes mixed in.
  task automatic queue_frames(input int target);
    int          made;
    int          len;
    int          kind;
    logic [7:0]  b;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom_range(0, 255));
          rx_stream.push_back(b);
        end
      end else begin
        len = payload_bytes(enabled_fields(burst_sel_q)) + 2;
        b = (kind < 18) ? header_q ^ 8'($urandom_range(1, 255)) : header_q;
        rx_stream.push_back(b);
        for (int i = 0; i < len - 2; i++) rx_stream.push_back(payload_byte());
        b = (kind >= 18 && kind < 28) ? delim_q ^ 8'($urandom_range(1, 255)) : delim_q;
        rx_stream.push_back(b);
      end
      made += len;
    end
    random_bytes += made;
  endtask

  initial begin : stimulus
    logic [15:0] edge_words [11];
    int unsigned send_gap   [4];
    int unsigned recv_stall [4];
    edge_words = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
                   16'h7FFF, 16'hFFFE, 16'h0000, 16'hFFFF, 16'hA55A};
    send_gap   = '{0, 51, 0, 16};
    recv_stall = '{0, 0, 51, 16};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting, no payload: one clean frame, then bad header and bad
    // delimiter together; the byte after the bad delimiter starts a new frame.
    rx_stream.push_back(HEADER_RST);
    rx_stream.push_back(DELIM_RST);
    rx_stream.push_back(8'h7F);
    rx_stream.push_back(8'h0C);
    wait_idle();

    // Every field on, all incline bits, header and delimiter at the extremes
    write_reg(REG_BURST_SEL, 16'hFFFF);
    write_reg(REG_INCLINE_CTRL, 16'h00FF);
    write_reg(REG_HEADER_BYTE, 16'h00FF);
    write_reg(REG_DELIM_BYTE, 16'h0000);
    rx_stream.push_back(8'hFF);
    foreach (edge_words[i]) begin
      rx_stream.push_back(edge_words[i][15:8]);
      rx_stream.push_back(edge_words[i][7:0]);
    end
    rx_stream.push_back(8'h00);
    wait_idle();

    // Shrink the burst mid-frame: position already at the new delimiter slot, so
    // the next byte closes the frame as the delimiter.
    write_reg(REG_BURST_SEL, 16'h0700);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h12);
    rx_stream.push_back(8'h34);
    wait_idle();
    write_reg(REG_BURST_SEL, 16'h8000);
    rx_stream.push_back(8'h00);
    // Bad header still runs the frame to its full length
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hAB);
    rx_stream.push_back(8'hCD);
    rx_stream.push_back(8'h00);

    // Random part: four idling phases, several register settings in each
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      sender_idle_pct    = send_gap[phase];
      receiver_stall_pct = recv_stall[phase];
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle();
        pick_settings();
        queue_frames(SEG_BYTES);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    fault_count += expected_frames.size();

    $display("checked %0d frames from %0d random bytes plus directed frames,", frames_checked,
             random_bytes);
    $display("across %0d register writes and four sender/receiver idling mixes", reg_writes);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sbfd_pkg.sv
src/sensor_burst_frame_deframer.sv
src/sbfd_checker.sv
tb/sensor_burst_frame_deframer_test.sv
